// File: rtl/core/gss_pkg.sv
`default_nettype none

package gss_pkg;

   localparam int unsigned FIELD_W = 10;
   localparam int unsigned BIN_W = 3;
   localparam int unsigned BIN_SLOTS = 8;

   localparam logic [FIELD_W-1:0] RUN_THR_RESET = 10'd180;
   localparam logic [FIELD_W-1:0] SPIKE_THR_RESET = 10'd40;

   localparam logic [FIELD_W-1:0] BAND_LOW = 10'd70;
   localparam logic [FIELD_W-1:0] BAND_HIGH = 10'd130;

   localparam logic [BIN_W-1:0] BIN_HIGH = 3'd6;
   localparam logic [BIN_W-1:0] BIN_NONE = 3'd7;

   localparam int unsigned CSR_ADDR_W = 1;
   localparam logic [CSR_ADDR_W-1:0] CSR_RUN_THR = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPIKE_THR = 1'b1;

   typedef struct packed {
      logic [FIELD_W-1:0] day_number;
      logic [FIELD_W-1:0] highest_level;
      logic [FIELD_W-1:0] peak_first_day;
      logic [FIELD_W-1:0] tie_day;
      logic               run_of_three;
      logic [FIELD_W-1:0] missing_days;
      logic [FIELD_W-1:0] spike_count;
      logic [FIELD_W-1:0] widest_swing;
      logic [FIELD_W-1:0] widest_swing_day;
   } stats_type;

   // tens bands 70..129, then 130 and up, else below 70
   function automatic logic [BIN_W-1:0] band_of(input logic [FIELD_W-1:0] r);
      logic [BIN_W-1:0] b;
      b = BIN_NONE;
      if (r >= BAND_HIGH) begin
         b = BIN_HIGH;
      end else if (r >= 10'd120) begin
         b = 3'd5;
      end else if (r >= 10'd110) begin
         b = 3'd4;
      end else if (r >= 10'd100) begin
         b = 3'd3;
      end else if (r >= 10'd90) begin
         b = 3'd2;
      end else if (r >= 10'd80) begin
         b = 3'd1;
      end else if (r >= BAND_LOW) begin
         b = 3'd0;
      end
      return b;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/glucose_sample_statistics_top.sv
`default_nettype none

// Running statistics over a stream of daily glucose readings (0 = not measured).
// Every accepted word yields one result word, in order, after the s1 and output
// registers; a new reading can be taken every cycle unless the output stalls.
// The s1 register is there for the histogram, whose seven bin counts sit in
// a small RAM with a registered read followed by an increment and write back
// (the last write is forwarded, so the same bin on consecutive days is fine).
// Highest level, runs, missing days and spikes update in the accept cycle.
// Day number and all counters stop at MAX_DAYS. The user must write thresholds
// through the csr port (index 0: run, 1: spike) only while idle; not enforced.
module glucose_sample_statistics_top #(
   parameter int unsigned MAX_DAYS = 512
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [gss_pkg::FIELD_W-1:0]    req_reading,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [gss_pkg::FIELD_W-1:0]    rsp_day_number,
   output logic      [gss_pkg::FIELD_W-1:0]    rsp_highest_level,
   output logic      [gss_pkg::FIELD_W-1:0]    rsp_peak_first_day,
   output logic      [gss_pkg::FIELD_W-1:0]    rsp_tie_day,
   output logic                                rsp_run_of_three,
   output logic      [gss_pkg::FIELD_W-1:0]    rsp_missing_days,
   output logic      [gss_pkg::FIELD_W-1:0]    rsp_spike_count,
   output logic      [gss_pkg::FIELD_W-1:0]    rsp_widest_swing,
   output logic      [gss_pkg::FIELD_W-1:0]    rsp_widest_swing_day,
   output logic      [gss_pkg::BIN_W-1:0]      rsp_bin_index,
   output logic      [gss_pkg::FIELD_W-1:0]    rsp_bin_count,
   input  wire logic                           csr_we,
   input  wire logic [gss_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [gss_pkg::FIELD_W-1:0]    csr_wdata
);

   logic [gss_pkg::FIELD_W-1:0] run_thr_ff, run_thr_in;
   logic [gss_pkg::FIELD_W-1:0] spike_thr_ff, spike_thr_in;

   logic                        s1_vld_ff, s1_vld_in;
   gss_pkg::stats_type          s1_stats_ff;
   logic                        out_vld_ff, out_vld_in;
   gss_pkg::stats_type          out_stats_ff;
   logic [gss_pkg::BIN_W-1:0]   out_bin_ff;
   logic [gss_pkg::FIELD_W-1:0] out_cnt_ff;

   logic                        accept;
   logic                        advance;
   gss_pkg::stats_type          stats;
   logic [gss_pkg::BIN_W-1:0]   s1_bin;
   logic [gss_pkg::FIELD_W-1:0] s1_cnt;

   gss_stats #(
      .MAX_DAYS(MAX_DAYS)
   ) u_stats (
      .clock    (clock),
      .reset    (reset),
      .step     (accept),
      .reading  (req_reading),
      .run_thr  (run_thr_ff),
      .spike_thr(spike_thr_ff),
      .stats    (stats)
   );

   gss_band #(
      .MAX_DAYS(MAX_DAYS)
   ) u_band (
      .clock  (clock),
      .reset  (reset),
      .step   (accept),
      .reading(req_reading),
      .advance(advance),
      .bin    (s1_bin),
      .count  (s1_cnt)
   );

   always_comb begin
      advance = s1_vld_ff && (!out_vld_ff || rsp_ready);
      req_ready = !s1_vld_ff || advance;
      accept = req_valid && req_ready;

      s1_vld_in = accept ? 1'b1 : (advance ? 1'b0 : s1_vld_ff);
      out_vld_in = advance ? 1'b1 : ((out_vld_ff && rsp_ready) ? 1'b0 : out_vld_ff);

      run_thr_in = run_thr_ff;
      spike_thr_in = spike_thr_ff;
      if (csr_we) begin
         unique case (csr_addr)
            gss_pkg::CSR_RUN_THR: run_thr_in = csr_wdata;
            gss_pkg::CSR_SPIKE_THR: spike_thr_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_thr_ff <= gss_pkg::RUN_THR_RESET;
         spike_thr_ff <= gss_pkg::SPIKE_THR_RESET;
         s1_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         run_thr_ff <= run_thr_in;
         spike_thr_ff <= spike_thr_in;
         s1_vld_ff <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_stats_ff <= stats;
      end
      if (advance) begin
         out_stats_ff <= s1_stats_ff;
         out_bin_ff <= s1_bin;
         out_cnt_ff <= s1_cnt;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_day_number = out_stats_ff.day_number;
   assign rsp_highest_level = out_stats_ff.highest_level;
   assign rsp_peak_first_day = out_stats_ff.peak_first_day;
   assign rsp_tie_day = out_stats_ff.tie_day;
   assign rsp_run_of_three = out_stats_ff.run_of_three;
   assign rsp_missing_days = out_stats_ff.missing_days;
   assign rsp_spike_count = out_stats_ff.spike_count;
   assign rsp_widest_swing = out_stats_ff.widest_swing;
   assign rsp_widest_swing_day = out_stats_ff.widest_swing_day;
   assign rsp_bin_index = out_bin_ff;
   assign rsp_bin_count = out_cnt_ff;

endmodule

`default_nettype wire

// File: rtl/core/gss_ram.sv
`default_nettype none

module gss_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/gss_stats.sv
`default_nettype none

module gss_stats #(
   parameter int unsigned MAX_DAYS = 512
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        step,
   input  wire logic [gss_pkg::FIELD_W-1:0] reading,
   input  wire logic [gss_pkg::FIELD_W-1:0] run_thr,
   input  wire logic [gss_pkg::FIELD_W-1:0] spike_thr,
   output gss_pkg::stats_type               stats
);

   localparam int unsigned CW = $clog2(MAX_DAYS + 1);
   localparam int unsigned WW = (CW > gss_pkg::FIELD_W) ? CW : gss_pkg::FIELD_W;
   localparam logic [CW-1:0] MAX_C = CW'(MAX_DAYS);
   localparam logic [CW-1:0] ONE_C = CW'(1);
   localparam logic [CW-1:0] TWO_C = CW'(2);

   function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
      return (v < MAX_C) ? v + ONE_C : MAX_C;
   endfunction

   function automatic logic [gss_pkg::FIELD_W-1:0] to_field(input logic [CW-1:0] v);
      logic [WW-1:0] t;
      t = WW'(v);
      return t[gss_pkg::FIELD_W-1:0];
   endfunction

   logic [gss_pkg::FIELD_W-1:0] prev_ff, prev_in;
   logic [gss_pkg::FIELD_W-1:0] prev2_ff, prev2_in;
   logic [CW-1:0]               days_ff, days_in;
   logic [gss_pkg::FIELD_W-1:0] peak_ff, peak_in;
   logic [CW-1:0]               peak_day_ff, peak_day_in;
   logic [CW-1:0]               tie_day_ff, tie_day_in;
   logic [CW-1:0]               zeros_ff, zeros_in;
   logic [CW-1:0]               spikes_ff, spikes_in;
   logic [gss_pkg::FIELD_W-1:0] jump_ff, jump_in;
   logic [CW-1:0]               jump_day_ff, jump_day_in;

   logic                        first_day;
   logic                        pair_ok;
   logic                        run;
   logic [gss_pkg::FIELD_W-1:0] diff;

   always_comb begin
      first_day = (days_ff == '0);
      days_in = sat_inc(days_ff);
      prev_in = reading;
      prev2_in = prev_ff;

      peak_in = peak_ff;
      peak_day_in = peak_day_ff;
      tie_day_in = tie_day_ff;
      if (first_day || reading > peak_ff) begin
         peak_in = reading;
         peak_day_in = days_in;
         tie_day_in = '0;
      end else if (reading == peak_ff && days_in != peak_day_ff) begin
         tie_day_in = days_in;
      end

      run = (days_ff >= TWO_C) && (reading > run_thr) && (prev_ff > run_thr) &&
            (prev2_ff > run_thr);

      zeros_in = (reading == '0) ? sat_inc(zeros_ff) : zeros_ff;

      pair_ok = !first_day && (reading != '0) && (prev_ff != '0);
      diff = (reading > prev_ff) ? reading - prev_ff : prev_ff - reading;
      spikes_in = spikes_ff;
      jump_in = jump_ff;
      jump_day_in = jump_day_ff;
      if (pair_ok) begin
         if (diff >= spike_thr) begin
            spikes_in = sat_inc(spikes_ff);
         end
         if (diff > jump_ff) begin
            jump_in = diff;
            jump_day_in = days_in - ONE_C;
         end
      end

      stats.day_number = to_field(days_in);
      stats.highest_level = peak_in;
      stats.peak_first_day = to_field(peak_day_in);
      stats.tie_day = to_field(tie_day_in);
      stats.run_of_three = run;
      stats.missing_days = to_field(zeros_in);
      stats.spike_count = to_field(spikes_in);
      stats.widest_swing = jump_in;
      stats.widest_swing_day = to_field(jump_day_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         prev2_ff <= '0;
         days_ff <= '0;
         peak_ff <= '0;
         peak_day_ff <= '0;
         tie_day_ff <= '0;
         zeros_ff <= '0;
         spikes_ff <= '0;
         jump_ff <= '0;
         jump_day_ff <= '0;
      end else if (step) begin
         prev_ff <= prev_in;
         prev2_ff <= prev2_in;
         days_ff <= days_in;
         peak_ff <= peak_in;
         peak_day_ff <= peak_day_in;
         tie_day_ff <= tie_day_in;
         zeros_ff <= zeros_in;
         spikes_ff <= spikes_in;
         jump_ff <= jump_in;
         jump_day_ff <= jump_day_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/gss_band.sv
`default_nettype none

module gss_band #(
   parameter int unsigned MAX_DAYS = 512
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        step,
   input  wire logic [gss_pkg::FIELD_W-1:0] reading,
   input  wire logic                        advance,
   output logic      [gss_pkg::BIN_W-1:0]   bin,
   output logic      [gss_pkg::FIELD_W-1:0] count
);

   localparam int unsigned CW = $clog2(MAX_DAYS + 1);
   localparam int unsigned WW = (CW > gss_pkg::FIELD_W) ? CW : gss_pkg::FIELD_W;
   localparam logic [CW-1:0] MAX_C = CW'(MAX_DAYS);
   localparam logic [CW-1:0] ONE_C = CW'(1);

   logic [gss_pkg::BIN_W-1:0]     bin_ff, bin_in;
   logic [gss_pkg::BIN_SLOTS-1:0] valid_ff, valid_in;
   logic                          last_vld_ff, last_vld_in;
   logic [gss_pkg::BIN_W-1:0]     last_bin_ff, last_bin_in;
   logic [CW-1:0]                 last_cnt_ff, last_cnt_in;

   logic [CW-1:0]                 rd_data;
   logic [CW-1:0]                 cur_cnt;
   logic [CW-1:0]                 new_cnt;
   logic                          wr_en;
   logic [WW-1:0]                 wide_cnt;

   gss_ram #(
      .WIDTH(CW),
      .DEPTH(gss_pkg::BIN_SLOTS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(bin_ff),
      .wr_data(new_cnt),
      .rd_en  (step),
      .rd_addr(bin_in),
      .rd_data(rd_data)
   );

   always_comb begin
      bin_in = gss_pkg::band_of(reading);

      // last write forwarded over the registered read
      if (last_vld_ff && last_bin_ff == bin_ff) begin
         cur_cnt = last_cnt_ff;
      end else if (valid_ff[bin_ff]) begin
         cur_cnt = rd_data;
      end else begin
         cur_cnt = '0;
      end
      new_cnt = (cur_cnt < MAX_C) ? cur_cnt + ONE_C : MAX_C;

      wr_en = advance && (bin_ff != gss_pkg::BIN_NONE);

      valid_in = valid_ff;
      last_vld_in = last_vld_ff;
      last_bin_in = last_bin_ff;
      last_cnt_in = last_cnt_ff;
      if (wr_en) begin
         valid_in[bin_ff] = 1'b1;
         last_vld_in = 1'b1;
         last_bin_in = bin_ff;
         last_cnt_in = new_cnt;
      end

      wide_cnt = WW'(new_cnt);
      bin = bin_ff;
      count = (bin_ff == gss_pkg::BIN_NONE) ? '0 : wide_cnt[gss_pkg::FIELD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         last_vld_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         last_vld_ff <= last_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         bin_ff <= bin_in;
      end
      last_bin_ff <= last_bin_in;
      last_cnt_ff <= last_cnt_in;
   end

endmodule

`default_nettype wire

// File: rtl/core/gss_checker.sv
`default_nettype none

module gss_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [gss_pkg::FIELD_W-1:0] rsp_day_number,
   input wire logic [gss_pkg::FIELD_W-1:0] rsp_highest_level,
   input wire logic [gss_pkg::FIELD_W-1:0] rsp_widest_swing,
   input wire logic [gss_pkg::FIELD_W-1:0] rsp_widest_swing_day,
   input wire logic [gss_pkg::BIN_W-1:0]   rsp_bin_index,
   input wire logic [gss_pkg::FIELD_W-1:0] rsp_bin_count
);

   // stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_day_number) &&
         $stable(rsp_bin_count) && $stable(rsp_highest_level))
      else $error("result word changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bin_index == gss_pkg::BIN_NONE |-> rsp_bin_count == '0)
      else $error("uncounted bin with nonzero count");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bin_index != gss_pkg::BIN_NONE |-> rsp_bin_count != '0)
      else $error("counted bin shows zero");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_widest_swing == '0 |-> rsp_widest_swing_day == '0)
      else $error("swing day without a swing");

endmodule

bind glucose_sample_statistics_top gss_checker u_gss_checker (.*);

`default_nettype wire

// File: verif/tb_glucose_sample_statistics_top.sv
`timescale 1ns / 1ps

module tb_glucose_sample_statistics_top;

   localparam int MAX_DAYS = 512;
   localparam int BAND_STEP = 10;
   localparam int WALK_ROWS = 22;
   localparam logic [gss_pkg::FIELD_W-1:0] LEVEL_TOP = 10'd1023;

   typedef struct packed {
      logic [gss_pkg::FIELD_W-1:0] day_number;
      logic [gss_pkg::FIELD_W-1:0] highest_level;
      logic [gss_pkg::FIELD_W-1:0] peak_first_day;
      logic [gss_pkg::FIELD_W-1:0] tie_day;
      logic                        run_of_three;
      logic [gss_pkg::FIELD_W-1:0] missing_days;
      logic [gss_pkg::FIELD_W-1:0] spike_count;
      logic [gss_pkg::FIELD_W-1:0] widest_swing;
      logic [gss_pkg::FIELD_W-1:0] widest_swing_day;
      logic [gss_pkg::BIN_W-1:0]   bin_index;
      logic [gss_pkg::FIELD_W-1:0] bin_count;
   } glucose_stats_type;

   typedef struct packed {
      logic [gss_pkg::FIELD_W-1:0] reading;
      bit                          typed;
      glucose_stats_type           stats;
   } reading_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid;
   logic req_ready;
   logic [gss_pkg::FIELD_W-1:0] req_reading;
   logic rsp_valid;
   logic rsp_ready;
   logic [gss_pkg::FIELD_W-1:0] rsp_day_number;
   logic [gss_pkg::FIELD_W-1:0] rsp_highest_level;
   logic [gss_pkg::FIELD_W-1:0] rsp_peak_first_day;
   logic [gss_pkg::FIELD_W-1:0] rsp_tie_day;
   logic rsp_run_of_three;
   logic [gss_pkg::FIELD_W-1:0] rsp_missing_days;
   logic [gss_pkg::FIELD_W-1:0] rsp_spike_count;
   logic [gss_pkg::FIELD_W-1:0] rsp_widest_swing;
   logic [gss_pkg::FIELD_W-1:0] rsp_widest_swing_day;
   logic [gss_pkg::BIN_W-1:0] rsp_bin_index;
   logic [gss_pkg::FIELD_W-1:0] rsp_bin_count;
   logic csr_we;
   logic [gss_pkg::CSR_ADDR_W-1:0] csr_addr;
   logic [gss_pkg::FIELD_W-1:0] csr_wdata;

   glucose_sample_statistics_top #(.MAX_DAYS(MAX_DAYS)) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_reading(req_reading),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_day_number(rsp_day_number),
      .rsp_highest_level(rsp_highest_level),
      .rsp_peak_first_day(rsp_peak_first_day),
      .rsp_tie_day(rsp_tie_day),
      .rsp_run_of_three(rsp_run_of_three),
      .rsp_missing_days(rsp_missing_days),
      .rsp_spike_count(rsp_spike_count),
      .rsp_widest_swing(rsp_widest_swing),
      .rsp_widest_swing_day(rsp_widest_swing_day),
      .rsp_bin_index(rsp_bin_index),
      .rsp_bin_count(rsp_bin_count),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // statistics mirror
   int run_limit = gss_pkg::RUN_THR_RESET;
   int spike_limit = gss_pkg::SPIKE_THR_RESET;
   int last_level = 0;
   int level_before_last = 0;
   int day_count = 0;
   int top_level = 0;
   int top_day = 0;
   int top_tie_day = 0;
   int unmeasured = 0;
   int spike_total = 0;
   int widest_jump = 0;
   int widest_jump_day = 0;
   int band_tally [7] = '{default: 0};

   glucose_stats_type pending_stats [$];
   int failures = 0;
   int readings_sent = 0;
   int results_seen = 0;
   int settings_used = 0;
   bit sender_calm = 1'b0;

   // first rows typed in by hand; the rest go through the mirror
   reading_row_type walk_rows [WALK_ROWS] = '{
      '{10'd0, 1'b1, '{10'd1, 10'd0, 10'd1, 10'd0, 1'b0, 10'd1, 10'd0, 10'd0, 10'd0,
                       gss_pkg::BIN_NONE, 10'd0}},
      '{10'd0, 1'b1, '{10'd2, 10'd0, 10'd1, 10'd2, 1'b0, 10'd2, 10'd0, 10'd0, 10'd0,
                       gss_pkg::BIN_NONE, 10'd0}},
      '{10'd1023, 1'b1, '{10'd3, 10'd1023, 10'd3, 10'd0, 1'b0, 10'd2, 10'd0, 10'd0,
                          10'd0, gss_pkg::BIN_HIGH, 10'd1}},
      '{10'd1023, 1'b1, '{10'd4, 10'd1023, 10'd3, 10'd4, 1'b0, 10'd2, 10'd0, 10'd0,
                          10'd0, gss_pkg::BIN_HIGH, 10'd2}},
      '{10'd1, 1'b1, '{10'd5, 10'd1023, 10'd3, 10'd4, 1'b0, 10'd2, 10'd1, 10'd1022,
                       10'd4, gss_pkg::BIN_NONE, 10'd0}},
      '{10'd200, 1'b0, '0},
      '{10'd300, 1'b0, '0},
      '{10'd250, 1'b0, '0},
      '{10'd181, 1'b0, '0},
      '{10'd180, 1'b0, '0},
      '{10'd0, 1'b0, '0},
      '{10'd100, 1'b0, '0},
      '{10'd69, 1'b0, '0},
      '{10'd70, 1'b0, '0},
      '{10'd79, 1'b0, '0},
      '{10'd80, 1'b0, '0},
      '{10'd129, 1'b0, '0},
      '{10'd130, 1'b0, '0},
      '{10'd119, 1'b0, '0},
      '{10'd140, 1'b0, '0},
      '{10'd100, 1'b0, '0},
      '{10'd61, 1'b0, '0}
   };

   function automatic int bump(input int v);
      return (v < MAX_DAYS) ? v + 1 : MAX_DAYS;
   endfunction

   function automatic glucose_stats_type absorb_reading(
      input logic [gss_pkg::FIELD_W-1:0] r);
      glucose_stats_type s;
      int rv;
      int prior;
      int day;
      int jump;
      logic [gss_pkg::BIN_W-1:0] band;
      rv = r;
      prior = day_count;
      day = bump(day_count);
      day_count = day;
      if (prior == 0 || rv > top_level) begin
         top_level = rv;
         top_day = day;
         top_tie_day = 0;
      end else if (rv == top_level && day != top_day) begin
         top_tie_day = day;
      end
      s.run_of_three = (day >= 3 && rv > run_limit && last_level > run_limit &&
                        level_before_last > run_limit);
      if (rv == 0) unmeasured = bump(unmeasured);
      if (prior != 0 && rv != 0 && last_level != 0) begin
         jump = (rv > last_level) ? rv - last_level : last_level - rv;
         if (jump >= spike_limit) spike_total = bump(spike_total);
         if (jump > widest_jump) begin
            widest_jump = jump;
            widest_jump_day = day - 1;
         end
      end
      if (rv < int'(gss_pkg::BAND_LOW)) begin
         band = gss_pkg::BIN_NONE;
      end else if (rv >= int'(gss_pkg::BAND_HIGH)) begin
         band = gss_pkg::BIN_HIGH;
      end else begin
         band = gss_pkg::BIN_W'((rv - int'(gss_pkg::BAND_LOW)) / BAND_STEP);
      end
      s.bin_index = band;
      s.bin_count = '0;
      if (band != gss_pkg::BIN_NONE) begin
         band_tally[band] = bump(band_tally[band]);
         s.bin_count = gss_pkg::FIELD_W'(band_tally[band]);
      end
      level_before_last = last_level;
      last_level = rv;
      s.day_number = gss_pkg::FIELD_W'(day);
      s.highest_level = gss_pkg::FIELD_W'(top_level);
      s.peak_first_day = gss_pkg::FIELD_W'(top_day);
      s.tie_day = gss_pkg::FIELD_W'(top_tie_day);
      s.missing_days = gss_pkg::FIELD_W'(unmeasured);
      s.spike_count = gss_pkg::FIELD_W'(spike_total);
      s.widest_swing = gss_pkg::FIELD_W'(widest_jump);
      s.widest_swing_day = gss_pkg::FIELD_W'(widest_jump_day);
      return s;
   endfunction

   function automatic int idle_cycles();
      int p;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [gss_pkg::FIELD_W-1:0] next_reading();
      int p;
      p = $urandom_range(0, 99);
      if (p < 8) return '0;
      if (p < 16) return gss_pkg::FIELD_W'(last_level);
      if (p < 21) return gss_pkg::FIELD_W'(top_level);
      if (p < 25) return LEVEL_TOP;
      if (p < 70) return gss_pkg::FIELD_W'($urandom_range(60, 320));
      return gss_pkg::FIELD_W'($urandom_range(1, 1023));
   endfunction

   task automatic check_stats(input glucose_stats_type want, input glucose_stats_type got);
      if (got.day_number !== want.day_number) begin
         $error("day_number: expected %0d, got %0d", want.day_number, got.day_number);
         failures++;
      end
      if (got.highest_level !== want.highest_level) begin
         $error("highest_level: expected %0d, got %0d", want.highest_level,
                got.highest_level);
         failures++;
      end
      if (got.peak_first_day !== want.peak_first_day) begin
         $error("peak_first_day: expected %0d, got %0d", want.peak_first_day,
                got.peak_first_day);
         failures++;
      end
      if (got.tie_day !== want.tie_day) begin
         $error("tie_day: expected %0d, got %0d", want.tie_day, got.tie_day);
         failures++;
      end
      if (got.run_of_three !== want.run_of_three) begin
         $error("run_of_three: expected %0d, got %0d", want.run_of_three,
                got.run_of_three);
         failures++;
      end
      if (got.missing_days !== want.missing_days) begin
         $error("missing_days: expected %0d, got %0d", want.missing_days,
                got.missing_days);
         failures++;
      end
      if (got.spike_count !== want.spike_count) begin
         $error("spike_count: expected %0d, got %0d", want.spike_count, got.spike_count);
         failures++;
      end
      if (got.widest_swing !== want.widest_swing) begin
         $error("widest_swing: expected %0d, got %0d", want.widest_swing,
                got.widest_swing);
         failures++;
      end
      if (got.widest_swing_day !== want.widest_swing_day) begin
         $error("widest_swing_day: expected %0d, got %0d", want.widest_swing_day,
                got.widest_swing_day);
         failures++;
      end
      if (got.bin_index !== want.bin_index) begin
         $error("bin_index: expected %0d, got %0d", want.bin_index, got.bin_index);
         failures++;
      end
      if (got.bin_count !== want.bin_count) begin
         $error("bin_count: expected %0d, got %0d", want.bin_count, got.bin_count);
         failures++;
      end
   endtask

   task automatic send_reading(input logic [gss_pkg::FIELD_W-1:0] r, input bit typed,
                               input glucose_stats_type typed_stats);
      glucose_stats_type predicted;
      int gap;
      gap = sender_calm ? 0 : idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_reading <= r;
      do @(posedge clock); while (!req_ready);
      predicted = absorb_reading(r);
      pending_stats.push_back(typed ? typed_stats : predicted);
      readings_sent++;
      if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_stats.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_thresholds(input logic [gss_pkg::FIELD_W-1:0] run,
                                 input logic [gss_pkg::FIELD_W-1:0] spike);
      settle();
      csr_we <= 1'b1;
      csr_addr <= gss_pkg::CSR_RUN_THR;
      csr_wdata <= run;
      @(posedge clock);
      csr_addr <= gss_pkg::CSR_SPIKE_THR;
      csr_wdata <= spike;
      @(posedge clock);
      csr_we <= 1'b0;
      run_limit = int'(run);
      spike_limit = int'(spike);
      settings_used++;
   endtask

   task automatic random_phase(input int count);
      for (int i = 0; i < count; i++) begin
         send_reading(next_reading(), 1'b0, '0);
      end
   endtask

   initial begin : result_side
      glucose_stats_type seen;
      int stall_left;
      bit calm;
      bit held;
      stall_left = 0;
      calm = 1'b0;
      held = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            seen = '{rsp_day_number, rsp_highest_level, rsp_peak_first_day, rsp_tie_day,
                     rsp_run_of_three, rsp_missing_days, rsp_spike_count,
                     rsp_widest_swing, rsp_widest_swing_day, rsp_bin_index,
                     rsp_bin_count};
            if (pending_stats.size() == 0) begin
               $error("result word with nothing expected, day_number %0d", rsp_day_number);
               failures++;
            end else begin
               check_stats(pending_stats.pop_front(), seen);
            end
            results_seen++;
         end
         if ($urandom_range(0, 39) == 0) calm = !calm;
         // long hold-off so the input side backs up
         if (!held && results_seen >= 260) begin
            held = 1'b1;
            stall_left = 150;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm) stall_left = idle_cycles();
         end
      end
   end

   initial begin : reading_side
      req_valid = 1'b0;
      req_reading = '0;
      csr_we = 1'b0;
      csr_addr = gss_pkg::CSR_RUN_THR;
      csr_wdata = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (walk_rows[i]) begin
         send_reading(walk_rows[i].reading, walk_rows[i].typed, walk_rows[i].stats);
      end

      // zero spike threshold: every nonzero pair is a spike
      set_thresholds('0, '0);
      random_phase(130);
      set_thresholds(LEVEL_TOP, LEVEL_TOP);
      random_phase(130);
      set_thresholds(gss_pkg::FIELD_W'($urandom_range(100, 250)), 10'd1);
      random_phase(130);
      set_thresholds(gss_pkg::FIELD_W'($urandom_range(0, 1023)),
                     gss_pkg::FIELD_W'($urandom_range(1, 1023)));
      random_phase(140);

      settle();
      repeat (8) @(posedge clock);
      $display("%0d readings under %0d threshold settings, %0d results compared",
               readings_sent, settings_used + 1, results_seen);
      $display("day count %0d, missing %0d, spikes %0d, biggest jump %0d",
               day_count, unmeasured, spike_total, widest_jump);
      if (failures == 0 && pending_stats.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

// File: glucose_sample_statistics_top.f
rtl/core/gss_pkg.sv
rtl/core/gss_ram.sv
rtl/core/gss_stats.sv
rtl/core/gss_band.sv
rtl/core/glucose_sample_statistics_top.sv
rtl/core/gss_checker.sv
verif/tb_glucose_sample_statistics_top.sv
